// ===== src/fp32mma_pkg.sv =====
// Shared constants, operation codes and a helper function for the fp32 matrix
// multiply-accumulate core. No dependencies.
`default_nettype none

package fp32mma_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 16;
    localparam int unsigned CFG_W           = 5;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned OP_W            = 3;
    localparam int unsigned POS_W           = 4;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned EXP_W           = 12;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_C  = 3'd2;
    localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_C  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd2;

    localparam logic [WORD_W-1:0] QNAN32 = 32'h7FC0_0000;
    localparam logic [WORD_W-1:0] INF32  = 32'h7F80_0000;

    // Position of the highest set bit; zero for a zero word.
    function automatic logic [5:0] top_bit(input logic [63:0] v);
        logic [5:0] t;
        t = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) t = 6'(i);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== src/fp32mma_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module fp32mma_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                    aclk,
    input  wire logic                                    en,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                        wdata,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/fp32mma_fma.sv =====
// Six-stage binary32 fused multiply-add, a * b + c with one rounding to
// nearest even. Depends on fp32mma_pkg.
`default_nettype none

module fp32mma_fma (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] c,
    output logic             out_valid,
    output logic      [31:0] res
);

    localparam int unsigned EW = fp32mma_pkg::EXP_W;

    function automatic logic [63:0] shr_sticky(input logic [63:0] v,
                                               input logic signed [EW-1:0] d);
        logic [5:0] s;
        s = d[5:0];
        if (d >= EW'(63)) return {63'd0, |v};
        return (v >> s) | {63'd0, |(v & ((64'd1 << s) - 64'd1))};
    endfunction

    logic [5:0] valid_reg;

    // Stage 1: decode, special cases, mantissa product.
    logic        sa, sb, sc, sp;
    logic [7:0]  ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic        az, bz, cz, spec1;
    logic [31:0] specv1;

    assign sa = a[31];
    assign sb = b[31];
    assign sc = c[31];
    assign sp = sa ^ sb;
    assign ea = a[30:23];
    assign eb = b[30:23];
    assign ec = c[30:23];
    assign fa = a[22:0];
    assign fb = b[22:0];
    assign fc = c[22:0];
    assign az = (ea == 8'd0) && (fa == 23'd0);
    assign bz = (eb == 8'd0) && (fb == 23'd0);
    assign cz = (ec == 8'd0) && (fc == 23'd0);

    always_comb begin
        spec1  = 1'b1;
        specv1 = c;
        if ((ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0)
            || (ec == 8'hFF && fc != 23'd0)) begin
            specv1 = fp32mma_pkg::QNAN32;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            if (az || bz) begin
                specv1 = fp32mma_pkg::QNAN32;
            end else if (ec == 8'hFF && sc != sp) begin
                specv1 = fp32mma_pkg::QNAN32;
            end else begin
                specv1 = {sp, fp32mma_pkg::INF32[30:0]};
            end
        end else if (ec == 8'hFF) begin
            specv1 = c;
        end else if (az || bz) begin
            specv1 = cz ? {sp & sc, 31'd0} : c;
        end else begin
            spec1 = 1'b0;
        end
    end

    logic        p1_spec, p1_sp, p1_sc, p1_cz;
    logic [31:0] p1_specv;
    logic [47:0] p1_prod;
    logic [23:0] p1_mc;
    logic [8:0]  p1_exy;
    logic [7:0]  p1_xc;

    always_ff @(posedge aclk) begin
        p1_spec  <= spec1;
        p1_specv <= specv1;
        p1_sp    <= sp;
        p1_sc    <= sc;
        p1_cz    <= cz;
        p1_prod  <= {24'd0, (ea != 8'd0), fa} * {24'd0, (eb != 8'd0), fb};
        p1_mc    <= {(ec != 8'd0), fc};
        p1_exy   <= 9'((ea != 8'd0) ? ea : 8'd1) + 9'((eb != 8'd0) ? eb : 8'd1);
        p1_xc    <= (ec != 8'd0) ? ec : 8'd1;
    end

    // Stage 2: normalize product and addend to bit 61.
    logic [5:0] sh_x, sh_y;
    assign sh_x = 6'd61 - fp32mma_pkg::top_bit({16'd0, p1_prod});
    assign sh_y = 6'd61 - fp32mma_pkg::top_bit({40'd0, p1_mc});

    logic                 p2_spec, p2_sp, p2_sc, p2_cz;
    logic [31:0]          p2_specv;
    logic [63:0]          p2_x, p2_y;
    logic signed [EW-1:0] p2_ex, p2_ey;

    always_ff @(posedge aclk) begin
        p2_spec  <= p1_spec;
        p2_specv <= p1_specv;
        p2_sp    <= p1_sp;
        p2_sc    <= p1_sc;
        p2_cz    <= p1_cz;
        p2_x     <= {16'd0, p1_prod} << sh_x;
        p2_y     <= {40'd0, p1_mc} << sh_y;
        p2_ex    <= $signed({3'd0, p1_exy}) - EW'(300) - $signed({6'd0, sh_x});
        p2_ey    <= $signed({4'd0, p1_xc}) - EW'(150) - $signed({6'd0, sh_y});
    end

    // Stage 3: align the smaller operand with sticky.
    logic                 p3_spec, p3_sp, p3_sc, p3_cz;
    logic [31:0]          p3_specv;
    logic [63:0]          p3_x, p3_y;
    logic signed [EW-1:0] p3_e;

    always_ff @(posedge aclk) begin
        p3_spec  <= p2_spec;
        p3_specv <= p2_specv;
        p3_sp    <= p2_sp;
        p3_sc    <= p2_sc;
        p3_cz    <= p2_cz;
        if (p2_cz) begin
            p3_x <= p2_x;
            p3_y <= p2_y;
            p3_e <= p2_ex;
        end else if (p2_ex >= p2_ey) begin
            p3_x <= p2_x;
            p3_y <= shr_sticky(p2_y, p2_ex - p2_ey);
            p3_e <= p2_ex;
        end else begin
            p3_x <= shr_sticky(p2_x, p2_ey - p2_ex);
            p3_y <= p2_y;
            p3_e <= p2_ey;
        end
    end

    // Stage 4: add or subtract magnitudes.
    logic [63:0] r4;
    logic        s4;
    always_comb begin
        if (p3_cz) begin
            r4 = p3_x;
            s4 = p3_sp;
        end else if (p3_sp == p3_sc) begin
            r4 = p3_x + p3_y;
            s4 = p3_sp;
        end else if (p3_x >= p3_y) begin
            r4 = p3_x - p3_y;
            s4 = p3_sp;
        end else begin
            r4 = p3_y - p3_x;
            s4 = p3_sc;
        end
    end

    logic                 p4_spec, p4_s;
    logic [31:0]          p4_specv;
    logic [63:0]          p4_r;
    logic signed [EW-1:0] p4_e;

    always_ff @(posedge aclk) begin
        // An exact zero from cancellation is +0.
        p4_spec  <= p3_spec || (!p3_cz && r4 == 64'd0);
        p4_specv <= p3_spec ? p3_specv : 32'd0;
        p4_s     <= s4;
        p4_r     <= r4;
        p4_e     <= p3_e;
    end

    // Stage 5: shift to 24 bits (or the subnormal limit), find guard and sticky.
    logic signed [EW-1:0] sh5, lim5;
    logic [5:0]           amt5;
    logic [24:0]          m5;
    logic                 g5, st5;

    always_comb begin
        sh5  = $signed({6'd0, fp32mma_pkg::top_bit(p4_r)}) - EW'(23);
        lim5 = -EW'(149) - p4_e;
        if (sh5 < lim5) sh5 = lim5;
        amt5 = 6'd0;
        m5   = 25'd0;
        g5   = 1'b0;
        st5  = 1'b0;
        if (sh5 <= EW'(0)) begin
            amt5 = 6'(-sh5);
            m5   = 25'(p4_r << amt5);
        end else if (sh5 < EW'(64)) begin
            amt5 = sh5[5:0];
            m5   = 25'(p4_r >> amt5);
            g5   = p4_r[amt5 - 6'd1];
            st5  = |(p4_r & ((64'd1 << (amt5 - 6'd1)) - 64'd1));
        end
    end

    logic                 p5_spec, p5_s, p5_g, p5_st;
    logic [31:0]          p5_specv;
    logic [24:0]          p5_m;
    logic signed [EW-1:0] p5_be;

    always_ff @(posedge aclk) begin
        p5_spec  <= p4_spec;
        p5_specv <= p4_specv;
        p5_s     <= p4_s;
        p5_g     <= g5;
        p5_st    <= st5;
        p5_m     <= m5;
        p5_be    <= p4_e + sh5 + EW'(150);
    end

    // Stage 6: round and pack.
    logic [24:0]          m6;
    logic signed [EW-1:0] be6;
    logic [31:0]          res6;

    always_comb begin
        m6  = p5_m + 25'(p5_g && (p5_st || p5_m[0]));
        be6 = p5_be;
        if (m6[24]) begin
            m6  = m6 >> 1;
            be6 = be6 + EW'(1);
        end
        if (p5_spec) begin
            res6 = p5_specv;
        end else if (m6 == 25'd0) begin
            res6 = {p5_s, 31'd0};
        end else if (!m6[23]) begin
            res6 = {p5_s, 8'd0, m6[22:0]};
        end else if (be6 >= EW'(255)) begin
            res6 = {p5_s, fp32mma_pkg::INF32[30:0]};
        end else begin
            res6 = {p5_s, be6[7:0], m6[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        res <= res6;
        if (!aresetn) begin
            valid_reg <= 6'd0;
        end else begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    assign out_valid = valid_reg[5];

endmodule

`default_nettype wire

// ===== src/fp32_matrix_multiply_accumulate_core.sv =====
// Top level of the fp32 matrix multiply-accumulate core: C := C + A * B.
// Depends on fp32mma_pkg, fp32mma_ram and fp32mma_fma.
`default_nettype none

//  channel   direction  signals                               purpose
//  s_        in         s_tvalid/s_tready/s_tuser/s_tdata     load, compute, read C
//  m_        out        m_tvalid/m_tready/m_tdata             C element read back
//  cfg_      in         cfg_valid/cfg_ready/cfg_index/cfg_data dimension registers
//
// Load transactions write one word each and do not hold off the next transaction.
// A read C transaction reads the C memory and then moves the word to the output register; the next
// transaction is accepted as soon as the word has moved there, even while the
// output stalls. In a compute transaction each
// fused multiply-add is one pass through the six-stage FMA unit, and the next
// step depends on its result. Reset is synchronous and active low; memory
// contents are not cleared and must be loaded before use.

module fp32_matrix_multiply_accumulate_core #(
    parameter int unsigned MAX_DIM = fp32mma_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // [2:0] operation
    input  wire logic [39:0] s_tdata,   // [3:0] row, [7:4] column, [39:8] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] c_value
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDC  = 3'd1;
    localparam logic [2:0] ST_RDAB = 3'd2;
    localparam logic [2:0] ST_F0   = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_WRC  = 3'd5;

    // Dimension registers keep the written bits; clamping happens on use.
    logic [4:0] rows_m_reg, cols_n_reg, inner_k_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg  <= 5'd16;
            cols_n_reg  <= 5'd16;
            inner_k_reg <= 5'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                fp32mma_pkg::REG_ROWS_M:  rows_m_reg  <= cfg_data;
                fp32mma_pkg::REG_COLS_N:  cols_n_reg  <= cfg_data;
                fp32mma_pkg::REG_INNER_K: inner_k_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Last index in use: zero acts as one, anything past MAX_DIM as MAX_DIM.
    function automatic logic [IW-1:0] last_of(input logic [4:0] v);
        if (v == 5'd0) return IW'(0);
        if (32'(v) > MAX_DIM) return IW'(MAX_DIM - 1);
        return IW'(v - 5'd1);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
        return AW'(32'(r) * MAX_DIM + 32'(c));
    endfunction

    // Input transaction decode.
    logic [2:0]    in_op;
    logic [3:0]    in_row, in_col;
    logic [31:0]   in_value;
    logic          in_inside, accept;
    logic [AW-1:0] in_addr;

    assign in_op     = s_tuser;
    assign in_row    = s_tdata[3:0];
    assign in_col    = s_tdata[7:4];
    assign in_value  = s_tdata[39:8];
    assign in_inside = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign in_addr   = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
    assign accept    = s_tvalid && s_tready;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic [IW-1:0] last_m_reg, last_n_reg, last_k_reg;
    logic [31:0]   acc_reg;
    logic          rd_pend_reg, rd_zero_reg;
    logic          m_tvalid_reg;
    logic [31:0]   m_tdata_reg;
    logic          move_out;

    logic [31:0] a_rdata, b_rdata, c_rdata, fma_res;
    logic        fma_out_valid;

    assign s_tready = (state_reg == ST_IDLE) && !rd_pend_reg;
    assign move_out = rd_pend_reg && (!m_tvalid_reg || m_tready);

    // Memory port control.
    logic          a_en, a_we, b_en, b_we, c_en, c_we;
    logic [AW-1:0] a_addr, b_addr, c_addr;
    logic [31:0]   c_wdata;

    always_comb begin
        a_en    = 1'b0;
        a_we    = 1'b0;
        b_en    = 1'b0;
        b_we    = 1'b0;
        c_en    = 1'b0;
        c_we    = 1'b0;
        a_addr  = in_addr;
        b_addr  = in_addr;
        c_addr  = in_addr;
        c_wdata = in_value;
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_inside) begin
                    a_en = (in_op == fp32mma_pkg::OP_LOAD_A);
                    a_we = a_en;
                    b_en = (in_op == fp32mma_pkg::OP_LOAD_B);
                    b_we = b_en;
                    c_en = (in_op == fp32mma_pkg::OP_LOAD_C)
                           || (in_op == fp32mma_pkg::OP_READ_C);
                    c_we = (in_op == fp32mma_pkg::OP_LOAD_C);
                end
            end
            ST_RDC: begin
                c_en   = 1'b1;
                c_addr = addr_of(i_reg, j_reg);
            end
            ST_RDAB: begin
                a_en   = 1'b1;
                b_en   = 1'b1;
                a_addr = addr_of(i_reg, k_reg);
                b_addr = addr_of(k_reg, j_reg);
            end
            ST_WRC: begin
                c_en    = 1'b1;
                c_we    = 1'b1;
                c_addr  = addr_of(i_reg, j_reg);
                c_wdata = acc_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_op == fp32mma_pkg::OP_COMPUTE) state_next = ST_RDC;
            end
            ST_RDC:  state_next = ST_RDAB;
            ST_RDAB: state_next = ST_F0;
            ST_F0:   state_next = ST_WAIT;
            ST_WAIT: begin
                if (fma_out_valid) state_next = (k_reg == last_k_reg) ? ST_WRC : ST_RDAB;
            end
            ST_WRC: begin
                state_next = (i_reg == last_m_reg && j_reg == last_n_reg) ? ST_IDLE : ST_RDC;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && in_op == fp32mma_pkg::OP_READ_C) begin
                rd_pend_reg <= 1'b1;
            end else if (move_out) begin
                rd_pend_reg <= 1'b0;
            end
            if (move_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload and loop counters.
    always_ff @(posedge aclk) begin
        if (accept) rd_zero_reg <= !in_inside;
        if (move_out) m_tdata_reg <= rd_zero_reg ? 32'd0 : c_rdata;
        case (state_reg)
            ST_IDLE: begin
                i_reg      <= IW'(0);
                j_reg      <= IW'(0);
                k_reg      <= IW'(0);
                last_m_reg <= last_of(rows_m_reg);
                last_n_reg <= last_of(cols_n_reg);
                last_k_reg <= last_of(inner_k_reg);
            end
            ST_RDAB: begin
                // The C word read in the previous state seeds the chain.
                if (k_reg == IW'(0)) acc_reg <= c_rdata;
            end
            ST_WAIT: begin
                if (fma_out_valid) begin
                    acc_reg <= fma_res;
                    if (k_reg != last_k_reg) k_reg <= k_reg + IW'(1);
                end
            end
            ST_WRC: begin
                k_reg <= IW'(0);
                if (j_reg == last_n_reg) begin
                    j_reg <= IW'(0);
                    i_reg <= i_reg + IW'(1);
                end else begin
                    j_reg <= j_reg + IW'(1);
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    fp32mma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_a_ram (
        .aclk(aclk), .en(a_en), .we(a_we), .addr(a_addr), .wdata(in_value),
        .rdata(a_rdata)
    );

    fp32mma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_b_ram (
        .aclk(aclk), .en(b_en), .we(b_we), .addr(b_addr), .wdata(in_value),
        .rdata(b_rdata)
    );

    fp32mma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_c_ram (
        .aclk(aclk), .en(c_en), .we(c_we), .addr(c_addr), .wdata(c_wdata),
        .rdata(c_rdata)
    );

    fp32mma_fma u_fma (
        .aclk(aclk), .aresetn(aresetn), .in_valid(state_reg == ST_F0),
        .a(a_rdata), .b(b_rdata), .c(acc_reg),
        .out_valid(fma_out_valid), .res(fma_res)
    );

    // A pending read only exists while no compute runs.
    a_rd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> state_reg == ST_IDLE)
        else $error("read pending outside idle");

    // The FMA result only arrives while the sequencer waits for it.
    a_fma_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        fma_out_valid |-> state_reg == ST_WAIT)
        else $error("FMA result outside wait state");

    // A compute transaction starts with a read of C.
    a_cmp_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == fp32mma_pkg::OP_COMPUTE) |=> state_reg == ST_RDC)
        else $error("compute did not start");

    // After a C write-back, either the next element starts or the block idles.
    a_wrc_next: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WRC |=> (state_reg == ST_RDC || state_reg == ST_IDLE))
        else $error("bad state after write-back");

endmodule

`default_nettype wire
